// ===== rtl/tmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmsf_pkg
// Shared constants and types of the trimmed mean smoothing filter.
// ----------------------------------------------------------------------------
package tmsf_pkg;

  localparam int SAMPLE_W          = 12;
  localparam int MAX_SAMPLE        = 4095;
  localparam int WEIGHT_W          = 9;
  localparam int WEIGHT_ONE        = 256;
  localparam int WEIGHT_RESET      = 77;
  localparam int BLOCK_LEN_DEFAULT = 8;
  localparam int DATA_W            = 2 * SAMPLE_W;

  // Load strobes for the per-channel datapath
  typedef struct packed {
    logic acc_en;   // sample word accepted
    logic last;     // accepted word closes the block
    logic mean_ld;  // trimmed sum -> mean register
    logic out_ld;   // mean -> smoothed output register
  } chan_ctrl_t;

endpackage

// ===== rtl/tmsf_chan.sv =====
// ----------------------------------------------------------------------------
// tmsf_chan
// One channel: block sum/min/max, trimmed sum, mean by reciprocal multiply
// and first-order lag against the previous output.
// ----------------------------------------------------------------------------
module tmsf_chan #(
  parameter int BLOCK_LEN = tmsf_pkg::BLOCK_LEN_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmsf_pkg::chan_ctrl_t          ctrl_i,
  input  logic [tmsf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [tmsf_pkg::WEIGHT_W-1:0] weight_i,
  output logic [tmsf_pkg::SAMPLE_W-1:0] filtered_o
);
  import tmsf_pkg::*;

  localparam int    SUM_W   = $clog2(BLOCK_LEN * MAX_SAMPLE + 1);
  localparam int    DIV_C   = BLOCK_LEN - 2;
  localparam int    DIV_L   = $clog2(DIV_C);
  localparam int    SHIFT_C = SUM_W + DIV_L;
  localparam longint RECIP_L = ((longint'(1) << SHIFT_C) + DIV_C - 1) / DIV_C;
  localparam logic [SUM_W:0] RECIP_C = RECIP_L[SUM_W:0];
  localparam int    PROD_W  = 2 * SUM_W + 1;
  localparam int    MIX_W   = SAMPLE_W + WEIGHT_W;

  logic [SUM_W-1:0]    sum_q, sum_d, sum_new;
  logic [SAMPLE_W-1:0] min_q, min_d, min_new;
  logic [SAMPLE_W-1:0] max_q, max_d, max_new;
  logic [SUM_W-1:0]    trim_q, trim_d;
  logic [SAMPLE_W-1:0] mean_q, mean_d;
  logic [SAMPLE_W-1:0] out_q, out_d;
  logic [PROD_W-1:0]   prod;
  logic [WEIGHT_W-1:0] inv_w;
  logic [MIX_W-1:0]    mix;

  // Running statistics including the incoming sample
  always_comb begin
    sum_new = sum_q + SUM_W'(sample_i);
    min_new = (sample_i < min_q) ? sample_i : min_q;
    max_new = (sample_i > max_q) ? sample_i : max_q;
    trim_d  = sum_new - SUM_W'(min_new) - SUM_W'(max_new);
  end

  always_comb begin
    sum_d = sum_q;
    min_d = min_q;
    max_d = max_q;
    if (ctrl_i.acc_en) begin
      if (ctrl_i.last) begin
        sum_d = '0;
        min_d = SAMPLE_W'(MAX_SAMPLE);
        max_d = '0;
      end else begin
        sum_d = sum_new;
        min_d = min_new;
        max_d = max_new;
      end
    end
  end

  // Exact floor division by the trimmed length
  always_comb begin
    prod   = PROD_W'(trim_q) * PROD_W'(RECIP_C);
    mean_d = prod[SHIFT_C +: SAMPLE_W];
  end

  // Lag: (prev*(256-w) + mean*w) >> 8
  always_comb begin
    inv_w = WEIGHT_W'(WEIGHT_ONE) - weight_i;
    mix   = MIX_W'(out_q) * MIX_W'(inv_w) + MIX_W'(mean_q) * MIX_W'(weight_i);
    out_d = mix[8 +: SAMPLE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      min_q <= SAMPLE_W'(MAX_SAMPLE);
      max_q <= '0;
      out_q <= '0;
    end else begin
      sum_q <= sum_d;
      min_q <= min_d;
      max_q <= max_d;
      if (ctrl_i.out_ld) begin
        out_q <= out_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en && ctrl_i.last) begin
      trim_q <= trim_d;
    end
    if (ctrl_i.mean_ld) begin
      mean_q <= mean_d;
    end
  end

  assign filtered_o = out_q;

endmodule

// ===== rtl/trimmed_mean_smoothing_filter.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_smoothing_filter
// Two-channel trimmed block mean with first-order lag smoothing.
// Throughput: one sample pair per cycle; a block's last pair waits for the trimmed sum stage.
// Result path: after the block's last pair is accepted, the result passes the
//   trimmed sum, mean multiply and lag multiply registers in turn.
// Reset: async active low; block statistics and outputs cleared, weight 77.
// ----------------------------------------------------------------------------
module trimmed_mean_smoothing_filter #(
  parameter int BLOCK_LEN = tmsf_pkg::BLOCK_LEN_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg write: smoothing_weight
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tmsf_pkg::WEIGHT_W-1:0] cfg_data_i,
  // tdata: [11:0] sample_ch0, [23:12] sample_ch1
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tmsf_pkg::DATA_W-1:0]   s_axis_tdata,
  // tdata: [11:0] filtered_ch0, [23:12] filtered_ch1
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tmsf_pkg::DATA_W-1:0]   m_axis_tdata
);
  import tmsf_pkg::*;

  localparam int CNT_W = $clog2(BLOCK_LEN);
  localparam logic [CNT_W-1:0] LAST_C = CNT_W'(BLOCK_LEN - 1);

  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [WEIGHT_W-1:0] weight_q, weight_sat;
  logic                trim_v_q, trim_v_d;
  logic                mean_v_q, mean_v_d;
  logic                out_v_q, out_v_d;
  logic                rdy_out, rdy_mean, rdy_trim;
  chan_ctrl_t          ctrl;
  logic [SAMPLE_W-1:0] filt0, filt1;

  assign cfg_ready_o = 1'b1;

  // Per-stage ready, output side first
  always_comb begin
    rdy_out       = !out_v_q || m_axis_tready;
    rdy_mean      = !mean_v_q || rdy_out;
    rdy_trim      = !trim_v_q || rdy_mean;
    s_axis_tready = rdy_trim || (cnt_q != LAST_C);
    ctrl.acc_en   = s_axis_tvalid && s_axis_tready;
    ctrl.last     = (cnt_q == LAST_C);
    ctrl.mean_ld  = trim_v_q && rdy_mean;
    ctrl.out_ld   = mean_v_q && rdy_out;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.acc_en) begin
      cnt_d = ctrl.last ? '0 : cnt_q + 1'b1;
    end
    trim_v_d = (ctrl.acc_en && ctrl.last) || (trim_v_q && !ctrl.mean_ld);
    mean_v_d = ctrl.mean_ld || (mean_v_q && !ctrl.out_ld);
    out_v_d  = ctrl.out_ld || (out_v_q && !m_axis_tready);
  end

  assign weight_sat = (weight_q > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      weight_q <= WEIGHT_W'(WEIGHT_RESET);
      trim_v_q <= 1'b0;
      mean_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      trim_v_q <= trim_v_d;
      mean_v_q <= mean_v_d;
      out_v_q  <= out_v_d;
      if (cfg_valid_i) begin
        weight_q <= cfg_data_i;
      end
    end
  end

  tmsf_chan #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_chan0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sample_i   (s_axis_tdata[SAMPLE_W-1:0]),
    .weight_i   (weight_sat),
    .filtered_o (filt0)
  );

  tmsf_chan #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_chan1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sample_i   (s_axis_tdata[DATA_W-1:SAMPLE_W]),
    .weight_i   (weight_sat),
    .filtered_o (filt1)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {filt1, filt0};

endmodule
